FILE: hdl/arlt_pkg.sv
package arlt_pkg;

	localparam int DEPTH_DEF = 1024;
	localparam int FILE_ID_WIDTH_DEF = 16;

	localparam int ADDR_W = 64;
	localparam int FILE_W = 16;
	localparam int LINE_W = 32;
	localparam int HINT_W = 10;
	localparam int COUNT_W = 11;

	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_FINALIZE = 2'd1,
		MODE_FIND = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2,
		ST_RSVD = 2'd3
	} status_t;

endpackage

FILE: hdl/arlt_req_if.sv
interface arlt_req_if;
	import arlt_pkg::*;

	logic valid;
	logic ready;
	mode_t mode;
	logic [ADDR_W-1:0] address;
	logic [FILE_W-1:0] file_id;
	logic [LINE_W-1:0] line_number;
	logic hint_valid;
	logic [HINT_W-1:0] hint_in;

	modport source(output valid, mode, address, file_id, line_number, hint_valid, hint_in,
		input ready);
	modport sink(input valid, mode, address, file_id, line_number, hint_valid, hint_in,
		output ready);
endinterface

FILE: hdl/arlt_rsp_if.sv
interface arlt_rsp_if;
	import arlt_pkg::*;

	logic valid;
	logic ready;
	status_t status;
	logic [FILE_W-1:0] found_file;
	logic [LINE_W-1:0] found_line;
	logic [HINT_W-1:0] index_out;
	logic [COUNT_W-1:0] count_out;

	modport source(output valid, status, found_file, found_line, index_out, count_out,
		input ready);
	modport sink(input valid, status, found_file, found_line, index_out, count_out,
		output ready);
endinterface

FILE: hdl/address_range_lookup_table_unit.sv
// Add, clear and a find on an empty table go from the accepted beat to the state that loads
// their result. A find that the hint settles reads the hinted entry and up to two after it;
// any other find runs a binary search, after the hint checks when they ran. The single table
// port and its registered read give each table read its own state ahead of the compare.
// Finalize runs the insertion sort of the keys, then the duplicate pass.
// One item is in work at a time: the next beat is taken the cycle after the result is loaded.
// Reset empties the table; entries need no clearing.
module address_range_lookup_table_unit #(
	parameter int DEPTH = arlt_pkg::DEPTH_DEF,
	parameter int FILE_ID_WIDTH = arlt_pkg::FILE_ID_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	arlt_req_if.sink req,
	arlt_rsp_if.source rsp
);
	import arlt_pkg::*;

	// Index width of the table, width of the entry count, and a width wide
	// enough to compare the hint with the count without losing bits.
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int HW = ((CW > HINT_W) ? CW : HINT_W) + 2;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [FILE_ID_WIDTH-1:0] file;
		logic [LINE_W-1:0] line;
	} entry_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_KEY, S_KEY2, S_CMP_RD, S_CMP, S_PLACE,
		S_D_RD0, S_D_FIRST, S_D_RD, S_D_CMP, S_D_LAST,
		S_F_H0, S_F_H0C, S_F_H1, S_F_H1C, S_F_H2, S_F_H2C,
		S_B_RD, S_B_CMP, S_B_END,
		S_DONE
	} state_t;

	state_t state_q;

	// The table itself: one write and one registered read per cycle.
	entry_t mem [DEPTH];
	entry_t rdata_q;
	logic mem_we;
	logic [IW-1:0] mem_wa;
	logic [IW-1:0] mem_ra;
	entry_t mem_wd;

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] i_q, j_q, w_q, lo_q, len_q;
	entry_t key_q, cur_q, cand_q;
	logic [ADDR_W-1:0] q_q;
	logic hv_q;
	logic [HINT_W-1:0] hint_q;

	// Pending result of the item in work, and the output register.
	status_t pn_status_q;
	logic [FILE_W-1:0] pn_file_q;
	logic [LINE_W-1:0] pn_line_q;
	logic [HINT_W-1:0] pn_idx_q;

	logic rsp_valid_q;
	status_t res_status_q;
	logic [FILE_W-1:0] res_file_q;
	logic [LINE_W-1:0] res_line_q;
	logic [HINT_W-1:0] res_idx_q;
	logic [CW-1:0] res_cnt_q;

	logic [HW-1:0] hint_x, cnt_x;
	logic [CW-1:0] half;

	assign hint_x = HW'(hint_q);
	assign cnt_x = HW'(cnt_q);
	assign half = len_q >> 1;

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.status = res_status_q;
	assign rsp.found_file = res_file_q;
	assign rsp.found_line = res_line_q;
	assign rsp.index_out = res_idx_q;
	assign rsp.count_out = COUNT_W'(res_cnt_q);

	// Port control of the table, decoded from the sequencer state.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = key_q;
		mem_ra = '0;
		case (state_q)
			S_IDLE: begin
				if (req.valid && req.mode == MODE_ADD && cnt_q < CW'(DEPTH)) begin
					mem_we = 1'b1;
					mem_wa = IW'(cnt_q);
					mem_wd = '{addr: req.address, file: FILE_ID_WIDTH'(req.file_id),
						line: req.line_number};
				end
			end
			S_KEY: mem_ra = IW'(i_q);
			S_CMP_RD: mem_ra = IW'(j_q - 1'b1);
			S_CMP: begin
				if (rdata_q.addr > key_q.addr) begin
					mem_we = 1'b1;
					mem_wa = IW'(j_q);
					mem_wd = rdata_q;
				end
			end
			S_PLACE: begin
				mem_we = 1'b1;
				mem_wa = IW'(j_q);
				mem_wd = key_q;
			end
			S_D_RD0: mem_ra = '0;
			S_D_RD: mem_ra = IW'(i_q);
			S_D_CMP: begin
				if (rdata_q.addr != cur_q.addr) begin
					mem_we = 1'b1;
					mem_wa = IW'(w_q);
					mem_wd = cur_q;
				end
			end
			S_D_LAST: begin
				mem_we = 1'b1;
				mem_wa = IW'(w_q);
				mem_wd = cur_q;
			end
			S_F_H0: mem_ra = IW'(hint_x);
			S_F_H1: mem_ra = IW'(hint_x + HW'(1));
			S_F_H2: mem_ra = IW'(hint_x + HW'(2));
			S_B_RD: mem_ra = IW'(lo_q + half);
			default: mem_ra = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// A result leaving the output register; when a new one is loaded in
			// the same cycle, the load below sets the flag instead.
			if (rsp_valid_q && rsp.ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						pn_status_q <= ST_OK;
						pn_file_q <= '0;
						pn_line_q <= '0;
						pn_idx_q <= '0;
						q_q <= req.address;
						hv_q <= req.hint_valid;
						hint_q <= req.hint_in;
						lo_q <= '0;
						len_q <= cnt_q;
						state_q <= S_DONE;
						case (req.mode)
							MODE_ADD: begin
								if (cnt_q < CW'(DEPTH)) begin
									cnt_q <= cnt_q + 1'b1;
								end else begin
									pn_status_q <= ST_FULL;
								end
							end
							MODE_FINALIZE: begin
								if (cnt_q == CW'(1)) begin
									state_q <= S_D_RD0;
								end else if (cnt_q != '0) begin
									i_q <= CW'(1);
									state_q <= S_KEY;
								end
							end
							MODE_FIND: begin
								if (cnt_q == '0) begin
									pn_status_q <= ST_MISS;
									pn_idx_q <= req.hint_valid ? req.hint_in : '0;
								end else if (req.hint_valid &&
									HW'(req.hint_in) < cnt_x) begin
									state_q <= S_F_H0;
								end else begin
									state_q <= S_B_RD;
								end
							end
							default: cnt_q <= '0;
						endcase
					end
				end
				// Insertion sort: take entry i as the key and shift larger ones up.
				S_KEY: state_q <= S_KEY2;
				S_KEY2: begin
					key_q <= rdata_q;
					j_q <= i_q;
					state_q <= S_CMP_RD;
				end
				S_CMP_RD: state_q <= S_CMP;
				S_CMP: begin
					if (rdata_q.addr > key_q.addr) begin
						j_q <= j_q - 1'b1;
						state_q <= (j_q == CW'(1)) ? S_PLACE : S_CMP_RD;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					i_q <= i_q + 1'b1;
					state_q <= (i_q + 1'b1 < cnt_q) ? S_KEY : S_D_RD0;
				end
				// Duplicate pass: of a run of equal addresses only the last survives.
				S_D_RD0: state_q <= S_D_FIRST;
				S_D_FIRST: begin
					cur_q <= rdata_q;
					i_q <= CW'(1);
					w_q <= '0;
					state_q <= (cnt_q == CW'(1)) ? S_D_LAST : S_D_RD;
				end
				S_D_RD: state_q <= S_D_CMP;
				S_D_CMP: begin
					if (rdata_q.addr != cur_q.addr) begin
						w_q <= w_q + 1'b1;
					end
					cur_q <= rdata_q;
					i_q <= i_q + 1'b1;
					state_q <= (i_q + 1'b1 == cnt_q) ? S_D_LAST : S_D_RD;
				end
				S_D_LAST: begin
					cnt_q <= w_q + 1'b1;
					state_q <= S_DONE;
				end
				// Hint checks: the hinted entry, then the one after it, then the one after that.
				S_F_H0: state_q <= S_F_H0C;
				S_F_H0C: begin
					if (rdata_q.addr <= q_q) begin
						if (hint_x + HW'(1) >= cnt_x) begin
							pn_file_q <= FILE_W'(rdata_q.file);
							pn_line_q <= rdata_q.line;
							pn_idx_q <= hint_q;
							state_q <= S_DONE;
						end else begin
							cand_q <= rdata_q;
							state_q <= S_F_H1;
						end
					end else begin
						state_q <= S_B_RD;
					end
				end
				S_F_H1: state_q <= S_F_H1C;
				S_F_H1C: begin
					if (rdata_q.addr > q_q) begin
						pn_file_q <= FILE_W'(cand_q.file);
						pn_line_q <= cand_q.line;
						pn_idx_q <= hint_q;
						state_q <= S_DONE;
					end else if (hint_x + HW'(2) >= cnt_x) begin
						pn_file_q <= FILE_W'(rdata_q.file);
						pn_line_q <= rdata_q.line;
						pn_idx_q <= hint_q + 1'b1;
						state_q <= S_DONE;
					end else begin
						cand_q <= rdata_q;
						state_q <= S_F_H2;
					end
				end
				S_F_H2: state_q <= S_F_H2C;
				S_F_H2C: begin
					if (rdata_q.addr > q_q) begin
						pn_file_q <= FILE_W'(cand_q.file);
						pn_line_q <= cand_q.line;
						pn_idx_q <= hint_q + 1'b1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_B_RD;
					end
				end
				// Binary search for the first entry above the query; once lo_q is above zero,
				// cand_q holds the entry just below lo_q.
				S_B_RD: state_q <= (len_q == '0) ? S_B_END : S_B_CMP;
				S_B_CMP: begin
					if (!(q_q < rdata_q.addr)) begin
						lo_q <= lo_q + half + 1'b1;
						len_q <= len_q - half - 1'b1;
						cand_q <= rdata_q;
					end else begin
						len_q <= half;
					end
					state_q <= S_B_RD;
				end
				S_B_END: begin
					if (lo_q == '0) begin
						pn_status_q <= ST_MISS;
						pn_idx_q <= hv_q ? hint_q : '0;
					end else begin
						pn_file_q <= FILE_W'(cand_q.file);
						pn_line_q <= cand_q.line;
						pn_idx_q <= HINT_W'(lo_q - 1'b1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						res_status_q <= pn_status_q;
						res_file_q <= pn_file_q;
						res_line_q <= pn_line_q;
						res_idx_q <= pn_idx_q;
						res_cnt_q <= cnt_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count beyond table depth");

	a_write_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> CW'(mem_wa) <= cnt_q)
		else $error("table write beyond the filled part");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !rsp_valid_q) |=> (rsp_valid_q && state_q == S_IDLE))
		else $error("finished result not loaded into the output register");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && res_status_q == ST_FULL) |-> res_cnt_q == CW'(DEPTH))
		else $error("table full reported below depth");

endmodule
